/* design/skvt_pkg.sv */
// Package for the symbol key/value table: field widths, action and status codes,
// FSM states, the commit command struct and the name normalization function.
// No dependencies.
package skvt_pkg;

    // Field widths fixed by the item format.
    localparam int ACT_W = 2;
    localparam int HEAD_W = 64;
    localparam int TAIL_W = 8;
    localparam int KEY_BYTES = 9;
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int VAL_W = 32;
    localparam int ST_W = 3;

    // Default sizing for the top level.
    localparam int DEF_ENTRIES = 16;
    localparam int DEF_NAME_BYTES = 9;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL = 3'd2;
    localparam logic [ST_W-1:0] ST_DELETED = 3'd3;
    localparam logic [ST_W-1:0] ST_DEL_MISS = 3'd4;
    localparam logic [ST_W-1:0] ST_HIT = 3'd5;
    localparam logic [ST_W-1:0] ST_MISS = 3'd6;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_SWEEP,
        S_COMMIT
    } t_state;

    // Commit command broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } t_cmd;

    // Builds the compare key: the name ends at its first zero byte and only
    // the first name_bytes bytes count; everything after the end is zero.
    function automatic logic [KEY_W-1:0] norm_key(input logic [HEAD_W-1:0] head,
                                                   input logic [TAIL_W-1:0] tail,
                                                   input int name_bytes);
        logic [KEY_W-1:0] key;
        logic [7:0] b;
        logic ended;
        key = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (i < 8) begin
                b = head[HEAD_W-1-8*i -: 8];
            end else begin
                b = tail;
            end
            if (i >= name_bytes || ended) begin
                b = 8'd0;
            end
            if (b == 8'd0) begin
                ended = 1'b1;
            end
            key[KEY_W-1-8*i -: 8] = b;
        end
        return key;
    endfunction

endpackage

/* design/skvt_cell.sv */
// One table cell: holds a single entry, compares it with the broadcast key and
// passes the hit / free-slot beat on to its right-hand neighbor each cycle.
// Depends on skvt_pkg.
module skvt_cell #(
    parameter int ENTRIES = skvt_pkg::DEF_ENTRIES,
    parameter int IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [skvt_pkg::KEY_W-1:0]     i_key,
    input  logic signed [skvt_pkg::VAL_W-1:0] i_value,
    input  skvt_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(ENTRIES)-1:0]     i_ins_idx,
    input  logic                           i_hit,
    input  logic signed [skvt_pkg::VAL_W-1:0] i_hit_value,
    input  logic                           i_free,
    input  logic [$clog2(ENTRIES)-1:0]     i_free_idx,
    output logic                           o_hit,
    output logic signed [skvt_pkg::VAL_W-1:0] o_hit_value,
    output logic                           o_free,
    output logic [$clog2(ENTRIES)-1:0]     o_free_idx,
    output logic                           o_valid
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                              r_valid;
    logic [skvt_pkg::KEY_W-1:0]        r_key;
    logic signed [skvt_pkg::VAL_W-1:0] r_value;
    logic                              r_match;
    logic                              r_hit;
    logic signed [skvt_pkg::VAL_W-1:0] r_hit_value;
    logic                              r_free;
    logic [IDX_W-1:0]                  r_free_idx;
    logic                              w_ins_here;

    assign w_ins_here = i_cmd.ins_en && (i_ins_idx == IDX_W'(IDX));

    // Entry storage; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ins_here) begin
            r_valid <= 1'b1;
        end else if (i_cmd.del_en && r_match) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_here) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // Local compare against the held key, and the beat passed to the right.
    // The first free cell from the left wins; at most one cell matches.
    always_ff @(posedge i_clk) begin
        r_match     <= r_valid && (r_key == i_key);
        r_hit       <= i_hit || r_match;
        r_hit_value <= r_match ? r_value : i_hit_value;
        r_free      <= i_free || !r_valid;
        r_free_idx  <= i_free ? i_free_idx : IDX_W'(IDX);
    end

    assign o_hit       = r_hit;
    assign o_hit_value = r_hit_value;
    assign o_free      = r_free;
    assign o_free_idx  = r_free_idx;
    assign o_valid     = r_valid;

endmodule

/* design/symbol_key_value_table_top.sv */
// Top level of the symbol key/value table: input capture, control sequencer,
// the row of skvt_cell instances and the output register.
// Depends on skvt_pkg and skvt_cell.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+----------------------------------------
//   in      | i_in_valid / o_in_ready   | i_action, i_key_head, i_key_tail, i_value
//   out     | o_out_valid / i_out_ready | o_status, o_found_value
//
// Each item passes from one acceptance to the next through capture, the cell
// compares, the ripple of the hit / free beat through the row of cells, and
// commit. The result is shown from the cycle after commit. Reset is
// synchronous and empties the table at once.
// A result not yet taken holds the commit until the output register frees;
// a new item is accepted while a result waits.
module symbol_key_value_table_top #(
    parameter int ENTRIES = skvt_pkg::DEF_ENTRIES,
    parameter int NAME_BYTES = skvt_pkg::DEF_NAME_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [skvt_pkg::ACT_W-1:0]        i_action,
    input  logic [skvt_pkg::HEAD_W-1:0]       i_key_head,
    input  logic [skvt_pkg::TAIL_W-1:0]       i_key_tail,
    input  logic signed [skvt_pkg::VAL_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [skvt_pkg::ST_W-1:0]         o_status,
    output logic signed [skvt_pkg::VAL_W-1:0] o_found_value
);

    localparam int IDX_W = $clog2(ENTRIES);

    skvt_pkg::t_state                  r_state;
    skvt_pkg::t_state                  n_state;
    logic [IDX_W-1:0]                  r_cnt;
    logic [skvt_pkg::ACT_W-1:0]        r_action;
    logic [skvt_pkg::KEY_W-1:0]        r_key;
    logic signed [skvt_pkg::VAL_W-1:0] r_value;
    logic                              r_out_valid;
    logic [skvt_pkg::ST_W-1:0]         r_status;
    logic signed [skvt_pkg::VAL_W-1:0] r_found;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_load;
    skvt_pkg::t_cmd                    w_cmd;
    logic [skvt_pkg::ST_W-1:0]         w_status;
    logic signed [skvt_pkg::VAL_W-1:0] w_found;

    logic                              w_hit [ENTRIES+1];
    logic signed [skvt_pkg::VAL_W-1:0] w_hit_value [ENTRIES+1];
    logic                              w_free [ENTRIES+1];
    logic [IDX_W-1:0]                  w_free_idx [ENTRIES+1];
    logic [ENTRIES-1:0]                w_valid;

    logic                              w_fin_hit;
    logic signed [skvt_pkg::VAL_W-1:0] w_fin_value;
    logic                              w_fin_free;
    logic [IDX_W-1:0]                  w_fin_idx;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // The beat entering the leftmost cell carries nothing found yet.
    assign w_hit[0]       = 1'b0;
    assign w_hit_value[0] = '0;
    assign w_free[0]      = 1'b0;
    assign w_free_idx[0]  = '0;

    assign w_fin_hit   = w_hit[ENTRIES];
    assign w_fin_value = w_hit_value[ENTRIES];
    assign w_fin_free  = w_free[ENTRIES];
    assign w_fin_idx   = w_free_idx[ENTRIES];

    // Row of cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        skvt_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_value     (r_value),
            .i_cmd       (w_cmd),
            .i_ins_idx   (w_fin_idx),
            .i_hit       (w_hit[g]),
            .i_hit_value (w_hit_value[g]),
            .i_free      (w_free[g]),
            .i_free_idx  (w_free_idx[g]),
            .o_hit       (w_hit[g+1]),
            .o_hit_value (w_hit_value[g+1]),
            .o_free      (w_free[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .o_valid     (w_valid[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            skvt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = skvt_pkg::S_COMPARE;
                end
            end
            skvt_pkg::S_COMPARE: begin
                n_state = skvt_pkg::S_SWEEP;
            end
            skvt_pkg::S_SWEEP: begin
                if (r_cnt == IDX_W'(ENTRIES - 1)) begin
                    n_state = skvt_pkg::S_COMMIT;
                end
            end
            skvt_pkg::S_COMMIT: begin
                if (w_out_free) begin
                    n_state = skvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skvt_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: ready, commit command and output load.
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            skvt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            skvt_pkg::S_COMMIT: begin
                w_load = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        w_cmd.ins_en = w_load && (r_action == skvt_pkg::ACT_INSERT) && !w_fin_hit && w_fin_free;
        w_cmd.del_en = w_load && (r_action == skvt_pkg::ACT_DELETE) && w_fin_hit;
    end

    // Result of the item from the final beat of the row.
    always_comb begin
        w_status = skvt_pkg::ST_MISS;
        w_found  = '0;
        case (r_action)
            skvt_pkg::ACT_INSERT: begin
                if (w_fin_hit) begin
                    w_status = skvt_pkg::ST_DUPLICATE;
                end else if (w_fin_free) begin
                    w_status = skvt_pkg::ST_INSERTED;
                end else begin
                    w_status = skvt_pkg::ST_FULL;
                end
            end
            skvt_pkg::ACT_DELETE: begin
                w_status = w_fin_hit ? skvt_pkg::ST_DELETED : skvt_pkg::ST_DEL_MISS;
            end
            skvt_pkg::ACT_SEARCH: begin
                if (w_fin_hit) begin
                    w_status = skvt_pkg::ST_HIT;
                    w_found  = w_fin_value;
                end
            end
            default: begin
                w_status = skvt_pkg::ST_MISS;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvt_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == skvt_pkg::S_SWEEP) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured item and output payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_key    <= skvt_pkg::norm_key(i_key_head, i_key_tail, NAME_BYTES);
            r_value  <= i_value;
        end
        if (w_load) begin
            r_status <= w_status;
            r_found  <= w_found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;

`ifndef SYNTHESIS
    // An accepted beat always starts the compare step.
    a_accept_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == skvt_pkg::S_COMPARE)
        else $error("accepted item did not enter compare");

    // An insert only ever lands in a cell that is empty.
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins_en |-> !w_valid[w_fin_idx])
        else $error("insert targets an occupied cell");

    // Insert and delete are never issued together.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ins_en && w_cmd.del_en))
        else $error("insert and delete issued in the same cycle");

    // A nonzero found value is only returned with a hit.
    a_found_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != skvt_pkg::ST_HIT) |-> o_found_value == '0)
        else $error("found value set without a hit");

    // Commit is never left while the output register is still full and stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::S_COMMIT && r_out_valid && !i_out_ready) |=>
            r_state == skvt_pkg::S_COMMIT)
        else $error("commit left while output stalled");
`endif

endmodule

/* tb/sv/symbol_key_value_table_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for symbol_key_value_table_top: a scoreboard class keeps its
// own copy of the table, predicts each result and checks the output beats in order.
// Depends on skvt_pkg and the symbol_key_value_table_top RTL.
module symbol_key_value_table_top_tb;

    localparam int TABLE_SLOTS = skvt_pkg::DEF_ENTRIES;
    localparam int NAME_LEN = skvt_pkg::DEF_NAME_BYTES;
    localparam logic [skvt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1350;
    localparam int QUIET_ITEMS = 150;
    localparam int POOL_SIZE = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_START = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 3 * (TABLE_SLOTS + 3);
    localparam logic signed [skvt_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [skvt_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Predicts the result of each accepted beat and checks output beats against it.
    class symtab_scoreboard;
        logic [skvt_pkg::KEY_W-1:0]        slot_key [TABLE_SLOTS];
        logic signed [skvt_pkg::VAL_W-1:0] slot_value [TABLE_SLOTS];
        bit                                slot_used [TABLE_SLOTS];
        logic [skvt_pkg::ST_W-1:0]         pending_status [$];
        logic signed [skvt_pkg::VAL_W-1:0] pending_value [$];
        int                                errors;

        function new();
            errors = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        // Updates the table copy for one accepted request and queues its result.
        function void note_request(input logic [skvt_pkg::ACT_W-1:0] action,
                                   input logic [skvt_pkg::HEAD_W-1:0] head,
                                   input logic [skvt_pkg::TAIL_W-1:0] tail,
                                   input logic signed [skvt_pkg::VAL_W-1:0] value);
            logic [skvt_pkg::KEY_W-1:0] key;
            logic [7:0] b;
            bit ended;
            int hit;
            int free_slot;
            logic [skvt_pkg::ST_W-1:0] st;
            logic signed [skvt_pkg::VAL_W-1:0] fv;
            key = '0;
            ended = 1'b0;
            // A name ends at its first zero byte; later bytes do not count.
            for (int i = 0; i < skvt_pkg::KEY_BYTES; i++) begin
                b = (i < 8) ? head[skvt_pkg::HEAD_W-1-8*i -: 8] : tail;
                if (ended || i >= NAME_LEN) b = 8'd0;
                if (b == 8'd0) ended = 1'b1;
                key[skvt_pkg::KEY_W-1-8*i -: 8] = b;
            end
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
                if (!slot_used[i] && free_slot < 0) free_slot = i;
            end
            st = skvt_pkg::ST_MISS;
            fv = '0;
            case (action)
                skvt_pkg::ACT_INSERT: begin
                    if (hit >= 0) begin
                        st = skvt_pkg::ST_DUPLICATE;
                    end else if (free_slot < 0) begin
                        st = skvt_pkg::ST_FULL;
                    end else begin
                        slot_key[free_slot] = key;
                        slot_value[free_slot] = value;
                        slot_used[free_slot] = 1'b1;
                        st = skvt_pkg::ST_INSERTED;
                    end
                end
                skvt_pkg::ACT_DELETE: begin
                    if (hit >= 0) begin
                        slot_used[hit] = 1'b0;
                        st = skvt_pkg::ST_DELETED;
                    end else begin
                        st = skvt_pkg::ST_DEL_MISS;
                    end
                end
                skvt_pkg::ACT_SEARCH: begin
                    if (hit >= 0) begin
                        st = skvt_pkg::ST_HIT;
                        fv = slot_value[hit];
                    end
                end
                default: begin
                end
            endcase
            pending_status.push_back(st);
            pending_value.push_back(fv);
        endfunction

        // Compares one output beat with the oldest predicted result.
        function void check_result(input logic [skvt_pkg::ST_W-1:0] status,
                                   input logic signed [skvt_pkg::VAL_W-1:0] found);
            logic [skvt_pkg::ST_W-1:0] st;
            logic signed [skvt_pkg::VAL_W-1:0] fv;
            if (pending_status.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: status %0d value %0d", status, found);
                return;
            end
            st = pending_status.pop_front();
            fv = pending_value.pop_front();
            if (status !== st || found !== fv) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected status %0d value %0d, got %0d %0d",
                             st, fv, status, found);
            end
        endfunction

        function int outstanding();
            return pending_status.size();
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [skvt_pkg::ACT_W-1:0]        i_action;
    logic [skvt_pkg::HEAD_W-1:0]       i_key_head;
    logic [skvt_pkg::TAIL_W-1:0]       i_key_tail;
    logic signed [skvt_pkg::VAL_W-1:0] i_value;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [skvt_pkg::ST_W-1:0]         o_status;
    logic signed [skvt_pkg::VAL_W-1:0] o_found_value;

    symtab_scoreboard sb;
    int cycle_count = 0;
    bit quiet = 1'b0;
    logic [7:0] pool_bytes [POOL_SIZE][skvt_pkg::KEY_BYTES];
    int pool_len [POOL_SIZE];

    symbol_key_value_table_top #(
        .ENTRIES(TABLE_SLOTS),
        .NAME_BYTES(NAME_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_key_head(i_key_head),
        .i_key_tail(i_key_tail),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_found_value(o_found_value)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle counter and run timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("symbol_key_value_table_top: mismatch");
            $finish;
        end
    end

    // Output monitor: every accepted result beat goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_status, o_found_value);
        end
    end

    // Receiver: random stall bursts, one long hold-off, and no stalls near the end.
    initial begin
        bit held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && cycle_count >= HOLD_START) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Offers one input beat and waits until it is accepted.
    task automatic offer_beat(input logic [skvt_pkg::ACT_W-1:0] action,
                              input logic [skvt_pkg::HEAD_W-1:0] head,
                              input logic [skvt_pkg::TAIL_W-1:0] tail,
                              input logic signed [skvt_pkg::VAL_W-1:0] value);
        i_in_valid <= 1'b1;
        i_action <= action;
        i_key_head <= head;
        i_key_tail <= tail;
        i_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(action, head, tail, value);
    endtask

    // Sends one beat, then maybe leaves the input idle for a short burst.
    task automatic send_request(input logic [skvt_pkg::ACT_W-1:0] action,
                                input logic [skvt_pkg::HEAD_W-1:0] head,
                                input logic [skvt_pkg::TAIL_W-1:0] tail,
                                input logic signed [skvt_pkg::VAL_W-1:0] value);
        offer_beat(action, head, tail, value);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Lays out a pool name as head and tail; bytes past the end may be garbage.
    task automatic render_name(input int idx, input bit scramble,
                               output logic [skvt_pkg::HEAD_W-1:0] head,
                               output logic [skvt_pkg::TAIL_W-1:0] tail);
        logic [7:0] b;
        for (int i = 0; i < skvt_pkg::KEY_BYTES; i++) begin
            if (i < pool_len[idx]) b = pool_bytes[idx][i];
            else if (i > pool_len[idx] && scramble) b = 8'($urandom);
            else b = 8'd0;
            if (i < 8) head[skvt_pkg::HEAD_W-1-8*i -: 8] = b;
            else tail = b;
        end
    endtask

    // Main stimulus: reset, directed cases, random traffic, drain and verdict.
    initial begin
        logic [skvt_pkg::HEAD_W-1:0] head;
        logic [skvt_pkg::TAIL_W-1:0] tail;
        logic [skvt_pkg::ACT_W-1:0] action;
        int pick;
        int r;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_action <= skvt_pkg::ACT_INSERT;
        i_key_head <= '0;
        i_key_tail <= '0;
        i_value <= '0;
        for (int n = 0; n < POOL_SIZE; n++) begin
            pool_len[n] = (n == 0) ? 0 : $urandom_range(1, skvt_pkg::KEY_BYTES);
            for (int i = 0; i < skvt_pkg::KEY_BYTES; i++)
                pool_bytes[n][i] = 8'($urandom_range(1, 255));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, then the empty name, which also matches with garbage after it.
        send_request(skvt_pkg::ACT_SEARCH, 64'h0, 8'h00, 32'sd5);
        send_request(skvt_pkg::ACT_DELETE, 64'h0, 8'h00, 32'sd0);
        send_request(skvt_pkg::ACT_INSERT, 64'h0, 8'h00, VAL_MAX);
        send_request(skvt_pkg::ACT_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 8'hFF, 32'sd0);
        // Full nine-byte name: insert, duplicate kept, the ninth byte counts.
        send_request(skvt_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, VAL_MIN);
        send_request(skvt_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'sd1);
        send_request(skvt_pkg::ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'sd0);
        send_request(skvt_pkg::ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFE, 32'sd0);
        send_request(ACT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'sd0);
        // Short name stored with garbage after its end, found by its clean form.
        send_request(skvt_pkg::ACT_INSERT, 64'h4100_A5A5_A5A5_A5A5, 8'h5A, -32'sd1);
        send_request(skvt_pkg::ACT_SEARCH, 64'h4100_0000_0000_0000, 8'h00, 32'sd0);
        send_request(skvt_pkg::ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'sd0);
        send_request(skvt_pkg::ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'sd0);
        // Fill the table until an insert reports full.
        for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
            send_request(skvt_pkg::ACT_INSERT, {8'(8'hC0 + i), 56'h0}, 8'h00, 32'(i));
        end
        // Duplicate on a full table, then reuse of a freed slot.
        send_request(skvt_pkg::ACT_INSERT, 64'h0, 8'h00, 32'sd9);
        send_request(skvt_pkg::ACT_DELETE, 64'hC500_0000_0000_0000, 8'h00, 32'sd0);
        send_request(skvt_pkg::ACT_INSERT, 64'hCE00_0000_0000_0000, 8'h00, 32'sd77);
        send_request(skvt_pkg::ACT_SEARCH, 64'hCE00_0000_0000_0000, 8'h00, 32'sd0);

        // Random traffic over a small pool of names, with some noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            pick = $urandom_range(0, POOL_SIZE - 1);
            render_name(pick, $urandom_range(0, 1), head, tail);
            r = $urandom_range(0, 99);
            if (r < 45) action = skvt_pkg::ACT_INSERT;
            else if (r < 70) action = skvt_pkg::ACT_DELETE;
            else if (r < 95) action = skvt_pkg::ACT_SEARCH;
            else if (r < 98) action = ACT_UNUSED;
            else begin
                action = 2'($urandom);
                head = {$urandom, $urandom};
                tail = 8'($urandom);
            end
            send_request(action, head, tail, $urandom);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then allow a few more item times.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("symbol_key_value_table_top: match");
        end else begin
            $display("symbol_key_value_table_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/skvt_pkg.sv
design/skvt_cell.sv
design/symbol_key_value_table_top.sv
tb/sv/symbol_key_value_table_top_tb.sv
